FILE: hdl/fat12_pkg.sv
// Shared types and constants of the FAT12 cluster chain walker.
package fat12_pkg;

    localparam int ENTRY_W   = 12;
    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 20;
    localparam int SIZE_W    = 32;
    localparam int PACK_W    = 24;
    localparam int PAIR_W    = 11;
    localparam int SPC_W     = 8;
    localparam int BPS_W     = 13;
    localparam int CBYTES_W  = SPC_W + BPS_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [ENTRY_W-1:0] CHAIN_END    = 12'hFF8;
    localparam logic [ENTRY_W:0]   CLUSTER_BASE = 13'd2;
    localparam logic [LEN_W-1:0]   LEN_MAX      = 20'hFFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECT_PER_CL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_S = 2'd2;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_WALK = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [ENTRY_W-1:0]   pair_entry;    // 2 * pair_index, the first entry of the pair
        logic [PACK_W-1:0]    packed_bytes;
        logic [ENTRY_W-1:0]   start_cluster;
        logic [SIZE_W-1:0]    file_size;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0] data_base_address;
        logic [SPC_W-1:0]  sectors_per_cluster;
        logic [BPS_W-1:0]  sector_bytes;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] segment_address;
        logic [LEN_W-1:0]  segment_length;
        logic              last_segment;
        logic              truncated;
    } t_seg;

endpackage

FILE: hdl/fat12_front.sv
// Front end: accepts input transfers, classifies them and queues them for the walker.
module fat12_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_action,
    input  logic [10:0]         i_pair_index,
    input  logic [23:0]         i_packed_bytes,
    input  logic [11:0]         i_start_cluster,
    input  logic [31:0]         i_file_size,
    output logic                o_item_valid,
    output fat12_pkg::t_item    o_item,
    input  logic                i_pop
);
    import fat12_pkg::*;

    t_item      r_q [2];
    logic       r_head;
    logic       r_tail;
    logic [1:0] r_fill;
    logic       w_push;
    logic       w_pop;
    t_item      w_item;

    assign o_ready      = (r_fill != 2'd2);
    assign o_item_valid = (r_fill != 2'd0);
    assign o_item       = r_q[r_head];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = i_pop && o_item_valid;

    always_comb begin
        w_item.kind          = t_kind'(i_action);
        w_item.pair_entry    = {i_pair_index, 1'b0};
        w_item.packed_bytes  = i_packed_bytes;
        w_item.start_cluster = i_start_cluster;
        w_item.file_size     = i_file_size;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_tail] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_tail <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_push) begin
                r_tail <= ~r_tail;
            end
            if (w_pop) begin
                r_head <= ~r_head;
            end
            case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

FILE: hdl/fat12_back.sv
// Back end: holds the FAT table, carries out loads and walks the cluster chain.
module fat12_back #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MAX_SEGMENTS  = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fat12_pkg::t_cfg     i_cfg,
    input  logic                i_item_valid,
    input  fat12_pkg::t_item    i_item,
    output logic                o_pop,
    output logic                o_out_valid,
    output fat12_pkg::t_seg     o_seg,
    input  logic                i_out_ready
);
    import fat12_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int RED_W = ENTRY_W + 8;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LD0  = 6'b000010,
        S_LD1  = 6'b000100,
        S_IDX  = 6'b001000,
        S_RD   = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    // Reduces a 12-bit cluster number modulo the table depth by restoring subtraction.
    function automatic logic [IDX_W-1:0] tab_mod(input logic [ENTRY_W-1:0] x);
        logic [RED_W-1:0] v;
        v = RED_W'(x);
        for (int k = 7; k >= 0; k--) begin
            if (v >= (RED_W'(TABLE_ENTRIES) << k)) begin
                v = v - (RED_W'(TABLE_ENTRIES) << k);
            end
        end
        return v[IDX_W-1:0];
    endfunction

    t_state                r_state;
    logic [ENTRY_W-1:0]    r_fat [TABLE_ENTRIES];
    logic [ENTRY_W-1:0]    r_rdata;
    logic [IDX_W-1:0]      r_idx;
    logic [PACK_W-1:0]     r_packed;
    logic [ENTRY_W-1:0]    r_cluster;
    logic [SIZE_W-1:0]     r_remaining;
    logic [CBYTES_W-1:0]   r_cbytes;
    logic [CBYTES_W-1:0]   r_len;
    logic [ADDR_W-1:0]     r_prod;
    logic [CNT_W-1:0]      r_count;
    logic                  r_out_valid;
    t_seg                  r_seg;

    logic                  w_we;
    logic [ENTRY_W-1:0]    w_wdata;
    logic [ENTRY_W:0]      w_rel;
    logic [ADDR_W-1:0]     w_rel32;
    logic [CBYTES_W-1:0]   w_len;
    logic                  w_chain_on;
    logic                  w_at_limit;
    logic                  w_out_free;
    logic                  w_done;

    assign o_pop       = (r_state == S_IDLE) && i_item_valid;
    assign o_out_valid = r_out_valid;
    assign o_seg       = r_seg;

    assign w_we    = (r_state == S_LD0) || (r_state == S_LD1);
    assign w_wdata = (r_state == S_LD0) ? r_packed[ENTRY_W-1:0]
                                        : r_packed[PACK_W-1:ENTRY_W];

    // Cluster numbers below two wrap, so the offset is taken as a signed value.
    assign w_rel   = {1'b0, r_cluster} - CLUSTER_BASE;
    assign w_rel32 = {{(ADDR_W-ENTRY_W-1){w_rel[ENTRY_W]}}, w_rel};
    assign w_len   = (r_remaining < SIZE_W'(r_cbytes)) ? r_remaining[CBYTES_W-1:0] : r_cbytes;

    assign w_chain_on = (r_rdata != '0) && (r_rdata < CHAIN_END);
    assign w_at_limit = (r_count == CNT_W'(MAX_SEGMENTS - 1));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_done     = !w_chain_on || w_at_limit;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_fat[r_idx] <= w_wdata;
        end
        r_rdata <= r_fat[r_idx];
    end

    // Datapath registers; the sequencer below decides when each one moves.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    r_idx         <= tab_mod(i_item.pair_entry);
                    r_packed      <= i_item.packed_bytes;
                    r_cluster     <= i_item.start_cluster;
                    r_remaining   <= i_item.file_size;
                    r_cbytes      <= CBYTES_W'(i_cfg.sectors_per_cluster)
                                     * CBYTES_W'(i_cfg.sector_bytes);
                end
            end
            S_LD0: begin
                r_idx <= (r_idx == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : r_idx + 1'b1;
            end
            S_IDX: begin
                r_idx  <= tab_mod(r_cluster);
                r_prod <= w_rel32 * ADDR_W'(r_cbytes);
                r_len  <= w_len;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    r_seg.segment_address <= i_cfg.data_base_address + r_prod;
                    r_seg.segment_length  <= r_len[CBYTES_W-1] ? LEN_MAX
                                                               : r_len[LEN_W-1:0];
                    r_seg.last_segment    <= w_done;
                    r_seg.truncated       <= w_chain_on && w_at_limit;
                    r_remaining           <= r_remaining - SIZE_W'(r_len);
                    r_cluster             <= r_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_count <= '0;
                        r_state <= (i_item.kind == KIND_WALK) ? S_IDX : S_LD0;
                    end
                end
                S_LD0:   r_state <= S_LD1;
                S_LD1:   r_state <= S_IDLE;
                S_IDX:   r_state <= S_RD;
                S_RD:    r_state <= S_EMIT;
                S_EMIT: begin
                    if (w_out_free) begin
                        r_count     <= r_count + 1'b1;
                        r_state     <= w_done ? S_IDLE : S_IDX;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("queue popped while the walker was busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_count < CNT_W'(MAX_SEGMENTS)))
        else $error("segment count passed its limit");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !i_out_ready) |=> (r_state == S_EMIT))
        else $error("walker left the emit step while the output was stalled");

    a_trunc_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_seg.truncated) |-> r_seg.last_segment)
        else $error("truncation flagged on a segment that is not the last");

    a_load_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LD0 || r_state == S_LD1) |=> !$rose(r_out_valid))
        else $error("a table load produced a segment");

endmodule

FILE: hdl/fat12_cluster_chain_walker.sv
// Top level of the FAT12 cluster chain walker: ports, configuration registers, front and back.
//
//  Channel  Dir  Fields (lowest bit first)                                     Handshake
//  s_axis   in   tuser: action; tdata: pair_index, packed_bytes, start_cluster,  tvalid/tready
//                file_size, 1 pad bit
//  m_axis   out  tuser: truncated; tlast: last_segment; tdata: segment_address,   tvalid/tready
//                segment_length, 4 pad bits
//  cfg      in   i_cfg_index selects the register, i_cfg_data carries its value  i_cfg_we
//
// The walker takes a load or a walk from the queue only when idle; a load then writes two table entries.
// A walk is taken from the queue, then each segment passes index reduction and address product,
// the registered table read, and the emit step, which holds while the output is stalled.
// Reset is synchronous, clears the queue and the sequencer and sets the configuration registers
// to their defaults; the table itself holds nothing valid until loaded.
// A two-entry queue lets the input side keep taking transfers while the walker is stalled
// on the output register.
module fat12_cluster_chain_walker #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MAX_SEGMENTS  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // pair_index, packed_bytes, start_cluster, file_size, pad
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // segment_address, segment_length, pad
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // truncated
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import fat12_pkg::*;

    t_cfg   r_cfg;
    logic   w_item_valid;
    t_item  w_item;
    logic   w_pop;
    t_seg   w_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_base_address   <= '0;
            r_cfg.sectors_per_cluster <= SPC_W'(1);
            r_cfg.sector_bytes        <= BPS_W'(512);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DATA_BASE:   r_cfg.data_base_address   <= i_cfg_data;
                CFG_SECT_PER_CL: r_cfg.sectors_per_cluster <= i_cfg_data[SPC_W-1:0];
                CFG_BYTES_PER_S: r_cfg.sector_bytes        <= i_cfg_data[BPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fat12_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_action        (s_axis_tuser),
        .i_pair_index    (s_axis_tdata[10:0]),
        .i_packed_bytes  (s_axis_tdata[34:11]),
        .i_start_cluster (s_axis_tdata[46:35]),
        .i_file_size     (s_axis_tdata[78:47]),
        .o_item_valid    (w_item_valid),
        .o_item          (w_item),
        .i_pop           (w_pop)
    );

    fat12_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_SEGMENTS  (MAX_SEGMENTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_pop        (w_pop),
        .o_out_valid  (m_axis_tvalid),
        .o_seg        (w_seg),
        .i_out_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {4'b0000, w_seg.segment_length, w_seg.segment_address};
    assign m_axis_tlast = w_seg.last_segment;
    assign m_axis_tuser = w_seg.truncated;

endmodule
